FILE: design/tcwp_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tcwp_pkg
// Shared types, register codes and character constants for the console
// wrap placer.
// -----------------------------------------------------------------------------
package tcwp_pkg;

   localparam int LINE_MAX_DEF = 63;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PW     = $clog2(QUEUE_DEPTH);

   // Register indexes (byte address divided by four).
   localparam logic [1:0] REG_LINE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_TOTAL_LINES = 2'd1;
   localparam logic [1:0] REG_WORD_WRAP   = 2'd2;
   localparam logic [1:0] REG_LEFT_MARGIN = 2'd3;

   // Register reset values.
   localparam logic [5:0]  LINE_WIDTH_RST  = 6'd38;
   localparam logic [15:0] TOTAL_LINES_RST = 16'd1724;
   localparam logic        WORD_WRAP_RST   = 1'b1;
   localparam logic [5:0]  LEFT_MARGIN_RST = 6'd0;

   // Character codes.
   localparam logic [7:0] CH_COLOR_A = 8'h01;
   localparam logic [7:0] CH_COLOR_B = 8'h02;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_NUL     = 8'h00;

   typedef struct packed {
      logic [5:0]  line_width;
      logic [15:0] total_lines;
      logic        word_wrap;
      logic [5:0]  left_margin;
   } cfg_type;

   typedef struct packed {
      logic        wr_any;
      logic        wr_ring;
      logic [15:0] ring_total;
   } cfg_evt_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       first;
      logic       last;
      logic       force_high;
      logic       color;
   } cmd_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       force_high;
      logic       last;
   } entry_type;

   typedef struct packed {
      logic [15:0] row_index;
      logic [5:0]  column_index;
      logic [7:0]  char_out;
      logic        write_enable;
      logic        clear_row_first;
      logic [15:0] filled_lines;
      logic        last_of_burst;
   } result_type;

endpackage
`default_nettype wire

FILE: design/tcwp_front.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tcwp_front
// Accepts message bytes and classifies color lead bytes before queuing.
// -----------------------------------------------------------------------------
module tcwp_front (
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_char_code,
   input  wire logic              req_first_of_message,
   input  wire logic              req_last_of_message,
   input  wire logic              req_force_high_bit,
   input  wire logic              q_full,
   output logic                   q_push,
   output tcwp_pkg::cmd_type      q_data
);
   import tcwp_pkg::*;

   always_comb begin
      req_ready          = !q_full;
      q_push             = req_valid && !q_full;
      q_data.char_code   = req_char_code;
      q_data.first       = req_first_of_message;
      q_data.last        = req_last_of_message;
      q_data.force_high  = req_force_high_bit;
      // A lead byte of one or two only sets the color bit.
      q_data.color       = (req_char_code == CH_COLOR_A) || (req_char_code == CH_COLOR_B);
   end

endmodule
`default_nettype wire

FILE: design/tcwp_queue.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tcwp_queue
// Small command queue between the front and back parts.
// -----------------------------------------------------------------------------
module tcwp_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire tcwp_pkg::cmd_type  push_data,
   output logic                    full,
   input  wire logic               pop,
   output logic                    valid,
   output tcwp_pkg::cmd_type       data
);
   import tcwp_pkg::*;

   cmd_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PW-1:0]   wr_ff, wr_in;
   logic [QUEUE_PW-1:0]   rd_ff, rd_in;
   logic [QUEUE_PW:0]     cnt_ff, cnt_in;

   always_comb begin
      full  = cnt_ff == (QUEUE_PW+1)'(QUEUE_DEPTH);
      valid = cnt_ff != '0;
      data  = slot_ff[rd_ff];
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QUEUE_PW+1)'(push) - (QUEUE_PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/tcwp_back.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tcwp_back
// Lookahead buffer, word-length scan and cursor placement engine.
// -----------------------------------------------------------------------------
module tcwp_back #(
   parameter int LINE_MAX = tcwp_pkg::LINE_MAX_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tcwp_pkg::cfg_type     cfg,
   input  wire tcwp_pkg::cfg_evt_type cfg_evt,
   input  wire logic                  cmd_valid,
   input  wire tcwp_pkg::cmd_type     cmd,
   output logic                       cmd_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output tcwp_pkg::result_type       rsp
);
   import tcwp_pkg::*;

   localparam int PW    = $clog2(LINE_MAX + 1);
   localparam int DEPTH = 1 << PW;
   localparam logic [PW-1:0] LM_P = PW'(LINE_MAX);
   localparam logic [5:0]    LM_6 = 6'(LINE_MAX);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RD    = 3'd1;
   localparam logic [2:0] S_EV    = 3'd2;
   localparam logic [2:0] S_COLOR = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;

   entry_type  mem [DEPTH];
   entry_type  rda_ff, rdb_ff;

   logic [2:0]    state_ff, state_in;
   logic [PW-1:0] head_ff, head_in, tail_ff, tail_in, cnt_ff, cnt_in, k_ff, k_in;
   logic          found_ff, found_in;
   logic [5:0]    tlen_ff, tlen_in;
   logic          mark_v_ff, mark_v_in;
   logic [PW-1:0] mark_ptr_ff, mark_ptr_in;
   logic          phase_ff, phase_in;
   cmd_type       cur_ff, cur_in;
   logic [5:0]    cc_ff, cc_in;
   logic [15:0]   row_ff, row_in, used_ff, used_in;
   logic          rp_ff, rp_in, color_ff, color_in;
   logic          hold_v_ff, hold_v_in, out_v_ff, out_v_in;
   result_type    hold_ff, hold_in, out_ff, out_in;

   logic          wr_en;
   logic [PW-1:0] scan_ptr;
   logic [5:0]    w, marg, rel_len, cc1, cc2;
   logic [15:0]   t, row1, row2;
   logic [16:0]   row_inc;
   logic [6:0]    cc_sum;
   logic          brk, blast, out_free, want_rel, do_rel, new_found, lf, is_nl, is_cr;
   logic [6:0]    b7;
   result_type    res;

   always_comb begin
      w    = (cfg.line_width == '0) ? 6'd1 :
             (cfg.line_width > LM_6) ? LM_6 : cfg.line_width;
      t    = (cfg.total_lines == '0) ? 16'd1 : cfg.total_lines;
      marg = (cfg.left_margin < w) ? cfg.left_margin : w - 6'd1;
      scan_ptr = head_ff + k_ff;

      // Break classification of the entry under the scan pointer.
      b7 = rdb_ff.char_code[6:0];
      if (cfg.word_wrap) begin
         brk = (rdb_ff.char_code == CH_NUL) || (b7 == CH_TAB[6:0]) ||
               (b7 == CH_CR[6:0]) || (b7 == CH_LF[6:0]) || (b7 == CH_SPACE[6:0]);
      end else begin
         brk = (rdb_ff.char_code <= CH_SPACE) || rdb_ff.char_code[7];
      end
      blast = rdb_ff.last || (mark_v_ff && (scan_ptr == mark_ptr_ff));

      out_free = !out_v_ff || rsp_ready;

      // Word length of the head entry.
      new_found = 1'b0;
      want_rel  = 1'b0;
      rel_len   = tlen_ff;
      if (found_ff) begin
         want_rel = 1'b1;
      end else if (7'(k_ff) >= {1'b0, w}) begin
         want_rel = 1'b1;
         rel_len  = w;
      end else if (k_ff < cnt_ff) begin
         if (brk) begin
            want_rel  = 1'b1;
            new_found = 1'b1;
            rel_len   = 6'(k_ff);
         end else if (blast) begin
            want_rel  = 1'b1;
            new_found = 1'b1;
            rel_len   = 6'(k_ff) + 6'd1;
         end
      end

      // Placement of the head entry.
      cc_sum = {1'b0, cc_ff} + {1'b0, rel_len};
      cc1    = ((rel_len != w) && (cc_sum > {1'b0, w})) ? 6'd0 : cc_ff;
      if (rp_ff) begin
         row1 = ((row_ff == '0) || (row_ff >= t)) ? t - 16'd1 : row_ff - 16'd1;
      end else begin
         row1 = row_ff;
      end
      is_nl   = rda_ff.char_code == CH_LF;
      is_cr   = rda_ff.char_code == CH_CR;
      lf      = (cc1 == '0) || (!is_nl && !is_cr && (cc1 >= w));
      row_inc = {1'b0, row1} + 17'd1;
      row2    = lf ? ((row_inc >= {1'b0, t}) ? 16'd0 : row_inc[15:0]) : row1;
      cc2     = lf ? marg : cc1;
      res.row_index       = row2;
      res.clear_row_first = lf;
      res.filled_lines    = (lf && (used_ff < t)) ? used_ff + 16'd1 : used_ff;
      res.last_of_burst   = 1'b0;
      if (is_nl || is_cr) begin
         res.column_index = '0;
         res.char_out     = '0;
         res.write_enable = 1'b0;
      end else begin
         res.column_index = cc2;
         res.char_out     = rda_ff.char_code |
                            {color_ff | rda_ff.force_high, 7'd0};
         res.write_enable = 1'b1;
      end

      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      cnt_in      = cnt_ff;
      k_in        = k_ff;
      found_in    = found_ff;
      tlen_in     = tlen_ff;
      mark_v_in   = mark_v_ff;
      mark_ptr_in = mark_ptr_ff;
      phase_in    = phase_ff;
      cur_in      = cur_ff;
      cc_in       = cc_ff;
      row_in      = row_ff;
      used_in     = used_ff;
      rp_in       = rp_ff;
      color_in    = color_ff;
      hold_v_in   = hold_v_ff;
      hold_in     = hold_ff;
      out_v_in    = out_v_ff && !rsp_ready;
      out_in      = out_ff;
      cmd_pop     = 1'b0;
      wr_en       = 1'b0;
      do_rel      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cur_in  = cmd;
               if (cmd.first && (cnt_ff != '0)) begin
                  // Close the waiting message and rescan from the head.
                  mark_v_in   = 1'b1;
                  mark_ptr_in = tail_ff - 1'b1;
                  k_in        = '0;
                  found_in    = 1'b0;
                  phase_in    = 1'b0;
                  state_in    = S_RD;
               end else begin
                  state_in = S_COLOR;
               end
            end
         end
         S_RD: begin
            state_in = S_EV;
         end
         S_EV: begin
            if (want_rel) begin
               if (!hold_v_ff || out_free) begin
                  do_rel = 1'b1;
                  state_in = S_RD;
               end
            end else if (k_ff < cnt_ff) begin
               k_in     = k_ff + 1'b1;
               state_in = S_RD;
            end else begin
               state_in = phase_ff ? S_FIN : S_COLOR;
            end
         end
         S_COLOR: begin
            if (cur_ff.first) begin
               color_in = cur_ff.color;
            end
            if (!(cur_ff.first && cur_ff.color) && (cnt_ff < LM_P)) begin
               wr_en    = 1'b1;
               tail_in  = tail_ff + 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               phase_in = 1'b1;
               state_in = S_RD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!hold_v_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_v_in      = 1'b1;
               out_in        = hold_ff;
               out_in.last_of_burst = 1'b1;
               hold_v_in     = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (do_rel) begin
         if (hold_v_ff) begin
            out_v_in = 1'b1;
            out_in   = hold_ff;
         end
         hold_v_in = 1'b1;
         hold_in   = res;
         row_in    = row2;
         used_in   = res.filled_lines;
         rp_in     = is_cr;
         cc_in     = (is_nl || is_cr) ? 6'd0 : cc2 + 6'd1;
         head_in   = head_ff + 1'b1;
         cnt_in    = cnt_ff - 1'b1;
         if (mark_v_ff && (mark_ptr_ff == head_ff)) begin
            mark_v_in = 1'b0;
         end
         tlen_in = rel_len - 6'd1;
         if (k_ff == '0) begin
            found_in = 1'b0;
         end else begin
            found_in = found_ff || new_found;
            k_in     = k_ff - 1'b1;
         end
      end

      if (cfg_evt.wr_any) begin
         k_in     = '0;
         found_in = 1'b0;
      end
      if (cfg_evt.wr_ring) begin
         row_in  = cfg_evt.ring_total - 16'd1;
         used_in = (used_ff > cfg_evt.ring_total) ? cfg_evt.ring_total : used_ff;
      end

      rsp_valid = out_v_ff;
      rsp       = out_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= '{char_code: cur_ff.char_code, force_high: cur_ff.force_high,
                           last: cur_ff.last};
      end
      rda_ff <= mem[head_ff];
      rdb_ff <= mem[scan_ptr];
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      hold_ff <= hold_in;
      out_ff  <= out_in;
      tlen_ff <= tlen_in;
      mark_ptr_ff <= mark_ptr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         head_ff   <= '0;
         tail_ff   <= '0;
         cnt_ff    <= '0;
         k_ff      <= '0;
         found_ff  <= 1'b0;
         mark_v_ff <= 1'b0;
         phase_ff  <= 1'b0;
         cc_ff     <= '0;
         row_ff    <= TOTAL_LINES_RST - 16'd1;
         used_ff   <= '0;
         rp_ff     <= 1'b0;
         color_ff  <= 1'b0;
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         cnt_ff    <= cnt_in;
         k_ff      <= k_in;
         found_ff  <= found_in;
         mark_v_ff <= mark_v_in;
         phase_ff  <= phase_in;
         cc_ff     <= cc_in;
         row_ff    <= row_in;
         used_ff   <= used_in;
         rp_ff     <= rp_in;
         color_ff  <= color_in;
         hold_v_ff <= hold_v_in;
         out_v_ff  <= out_v_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/text_console_wrap_placer_core.sv
`default_nettype none
// -----------------------------------------------------------------------------
// text_console_wrap_placer_core
// Word-wrapping placer that maps message bytes onto a ring of console rows.
// -----------------------------------------------------------------------------
// Each input byte passes through the pop, buffer write, closing read and
// evaluate, and finish steps, plus one lookahead memory read and one
// evaluate for every word byte the scan walks over and for every placement
// it releases. A word waits for its break byte; a first mark flushes
// the waiting bytes.
// Reset clears all control state at once; no clearing pass is needed since the
// lookahead memory content is never used before it is written.
module text_console_wrap_placer_core #(
   parameter int LINE_MAX = tcwp_pkg::LINE_MAX_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Input byte channel.
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_char_code,
   input  wire logic         req_first_of_message,
   input  wire logic         req_last_of_message,
   input  wire logic         req_force_high_bit,
   // Placement result channel.
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [15:0]       rsp_row_index,
   output logic [5:0]        rsp_column_index,
   output logic [7:0]        rsp_char_out,
   output logic              rsp_write_enable,
   output logic              rsp_clear_row_first,
   output logic [15:0]       rsp_filled_lines,
   output logic              rsp_last_of_burst,
   // Register port.
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [3:0]   paddr,
   input  wire logic [31:0]  pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import tcwp_pkg::*;

   // Configuration registers. A write transfer completes in the access phase;
   // pready is tied high so no access ever has wait states.
   logic [5:0]  line_width_ff, line_width_in;
   logic [15:0] total_lines_ff, total_lines_in;
   logic        word_wrap_ff, word_wrap_in;
   logic [5:0]  left_margin_ff, left_margin_in;
   logic        wr_stb;
   logic [1:0]  reg_idx;
   cfg_type     cfg;
   cfg_evt_type cfg_evt;

   logic        q_full, q_push, q_pop, q_valid;
   cmd_type     q_wdata, q_rdata;
   result_type  res;

   always_comb begin
      pready  = 1'b1;
      reg_idx = paddr[3:2];
      wr_stb  = psel && penable && pwrite;

      line_width_in  = line_width_ff;
      total_lines_in = total_lines_ff;
      word_wrap_in   = word_wrap_ff;
      left_margin_in = left_margin_ff;
      prdata         = '0;
      unique case (reg_idx)
         REG_LINE_WIDTH: begin
            prdata = 32'(line_width_ff);
            if (wr_stb) line_width_in = pwdata[5:0];
         end
         REG_TOTAL_LINES: begin
            prdata = 32'(total_lines_ff);
            if (wr_stb) total_lines_in = pwdata[15:0];
         end
         REG_WORD_WRAP: begin
            prdata = 32'(word_wrap_ff);
            if (wr_stb) word_wrap_in = pwdata[0];
         end
         REG_LEFT_MARGIN: begin
            prdata = 32'(left_margin_ff);
            if (wr_stb) left_margin_in = pwdata[5:0];
         end
         default: begin
            prdata = '0;
         end
      endcase

      cfg.line_width  = line_width_ff;
      cfg.total_lines = total_lines_ff;
      cfg.word_wrap   = word_wrap_ff;
      cfg.left_margin = left_margin_ff;

      // Any write restarts the word scan; a ring size write also moves the
      // current row to the top of the new ring and caps the fill count.
      cfg_evt.wr_any     = wr_stb;
      cfg_evt.wr_ring    = wr_stb && (reg_idx == REG_TOTAL_LINES);
      cfg_evt.ring_total = (pwdata[15:0] == '0) ? 16'd1 : pwdata[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff  <= LINE_WIDTH_RST;
         total_lines_ff <= TOTAL_LINES_RST;
         word_wrap_ff   <= WORD_WRAP_RST;
         left_margin_ff <= LEFT_MARGIN_RST;
      end else begin
         line_width_ff  <= line_width_in;
         total_lines_ff <= total_lines_in;
         word_wrap_ff   <= word_wrap_in;
         left_margin_ff <= left_margin_in;
      end
   end

   // The front takes a transfer whenever the command queue has room, so it
   // keeps accepting bytes while the back end is draining a word.
   tcwp_front u_front (
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_char_code        (req_char_code),
      .req_first_of_message (req_first_of_message),
      .req_last_of_message  (req_last_of_message),
      .req_force_high_bit   (req_force_high_bit),
      .q_full               (q_full),
      .q_push               (q_push),
      .q_data               (q_wdata)
   );

   tcwp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .data      (q_rdata)
   );

   // The back end holds one finished placement until it knows whether another
   // follows, which is how the last placement of a burst gets its flag.
   tcwp_back #(
      .LINE_MAX (LINE_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cfg_evt   (cfg_evt),
      .cmd_valid (q_valid),
      .cmd       (q_rdata),
      .cmd_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (res)
   );

   always_comb begin
      rsp_row_index       = res.row_index;
      rsp_column_index    = res.column_index;
      rsp_char_out        = res.char_out;
      rsp_write_enable    = res.write_enable;
      rsp_clear_row_first = res.clear_row_first;
      rsp_filled_lines    = res.filled_lines;
      rsp_last_of_burst   = res.last_of_burst;
   end

endmodule
`default_nettype wire

FILE: design/tcwp_checker.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tcwp_checker
// Port-level checks for the console wrap placer, bound to the top level.
// -----------------------------------------------------------------------------
module tcwp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [5:0]  rsp_column_index,
   input wire logic [7:0]  rsp_char_out,
   input wire logic        rsp_write_enable,
   input wire logic        pready
);

   // A result stays offered until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   // Nothing is offered right after reset.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // Line control placements carry neither a column nor a character.
   a_ctrl_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> rsp_column_index == 6'd0 && rsp_char_out == 8'd0)
      else $error("line control placement with payload");

   // The register port never inserts wait states.
   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("register port stalled");

endmodule

bind text_console_wrap_placer_core tcwp_checker u_tcwp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_column_index (rsp_column_index),
   .rsp_char_out     (rsp_char_out),
   .rsp_write_enable (rsp_write_enable),
   .pready           (pready)
);
`default_nettype wire
